FILE: sv/tldt_pkg.sv
// Shared types and constants for the two-level deadline timer.
// Holds the opcode and register index codes and the field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tldt_pkg;

   // Width of the tick counter and of every stored deadline.
   localparam int TICK_W     = 64;
   localparam int DELAY_W    = 48;
   localparam int CHECK_W    = 64;
   localparam int OUT_TIME_W = 64;
   localparam int GAP_W      = 32;
   localparam int OP_W       = 2;

   // Beat layout on the two data buses, padded to whole bytes.
   localparam int REQ_DATA_W = DELAY_W + CHECK_W;
   localparam int RSP_FIELDS_W = 1 + OUT_TIME_W + 1 + OUT_TIME_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration register index.
   localparam int CSR_IDX_W = 1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_CHECK = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_GAP  = 1'd0,
      CSR_SAFE_GAP = 1'd1
   } csr_idx_type;

   localparam logic [GAP_W-1:0] MIN_GAP_RESET  = GAP_W'(16000);
   localparam logic [GAP_W-1:0] SAFE_GAP_RESET = GAP_W'(1600000);

endpackage

`default_nettype wire

FILE: sv/two_level_deadline_timer.sv
// Two-level deadline timer: tick counter, current/next deadline slots and compare.
// Depends on tldt_pkg for widths, opcodes and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one request beat per clock while the response side does not
// stall and returns exactly one response beat for each, in order. A request is
// captured in an input register; once the response register can take it, the
// tick increment, the compare against the armed value, the promotion of the
// next deadline and the re-arm, or the insert of a set or the compare of a
// check, update the timer state and fill the response register. A stall on the
// response side holds both registers, and the request side keeps accepting
// while either register has room. Writes to min_gap and safe_gap are always
// taken and apply to the following requests; write them only while idle.
module two_level_deadline_timer (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // tdata, from bit 0: delay_ticks[47:0], check_deadline[63:0].
   input  wire  [tldt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: opcode[1:0].
   input  wire  [tldt_pkg::OP_W-1:0]            req_tuser,
   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // tdata, from bit 0: wake, deadline[63:0], expired, ticks_now[63:0], zero pad.
   output logic [tldt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration write channel.
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tldt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [tldt_pkg::GAP_W-1:0]           csr_wdata
);
   import tldt_pkg::*;

   // Configuration registers.
   logic [GAP_W-1:0]   min_gap_ff, safe_gap_ff;

   // Input register stage.
   logic               in_valid_ff;
   op_type             in_op_ff;
   logic [DELAY_W-1:0] in_delay_ff;
   logic [CHECK_W-1:0] in_check_ff;

   // Timer state.
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  cur_ff, cur_in;
   logic [TICK_W-1:0]  next_ff, next_in;
   logic [TICK_W-1:0]  armval_ff, armval_in;
   logic               armed_ff, armed_in;

   // Response register stage.
   logic                  out_valid_ff;
   logic                  wake_ff, wake_in;
   logic [OUT_TIME_W-1:0] dl_ff, dl_in;
   logic                  expired_ff, expired_in;

   logic advance;

   // Work on the held request whenever the response register can take it.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Datapath temporaries.
   logic [TICK_W-1:0] tick_inc, earliest_tick, gap, backup, set_dl, earliest;
   logic              match;

   // Single pass over one request: compare, promote and re-arm on a tick,
   // insert on a set, compare on a check.
   always_comb begin
      tick_in    = tick_ff;
      cur_in     = cur_ff;
      next_in    = next_ff;
      armval_in  = armval_ff;
      armed_in   = armed_ff;
      wake_in    = 1'b0;
      dl_in      = '0;
      expired_in = 1'b0;

      tick_inc      = tick_ff + TICK_W'(1);
      earliest_tick = tick_inc + TICK_W'(min_gap_ff);
      match         = armed_ff && (tick_inc >= armval_ff);
      gap           = next_ff - cur_ff;
      backup        = next_ff + TICK_W'(safe_gap_ff);
      set_dl        = tick_ff + TICK_W'(in_delay_ff);
      earliest      = tick_ff + TICK_W'(min_gap_ff);

      case (in_op_ff)
         OP_TICK: begin
            tick_in = tick_inc;
            if (match) begin
               wake_in  = 1'b1;
               armed_in = 1'b0;
               cur_in   = next_ff;
               if (next_ff != '0) begin
                  next_in = (gap < TICK_W'(safe_gap_ff)) ? backup : '0;
                  // The promoted deadline is armed no earlier than now + min_gap.
                  armed_in  = 1'b1;
                  armval_in = (next_ff <= earliest_tick) ? earliest_tick : next_ff;
               end
            end
         end
         OP_SET: begin
            dl_in = OUT_TIME_W'(set_dl);
            if (set_dl > tick_ff) begin
               if (cur_ff == '0 || set_dl < cur_ff) begin
                  next_in   = cur_ff;
                  cur_in    = set_dl;
                  armed_in  = 1'b1;
                  armval_in = (set_dl <= earliest) ? earliest : set_dl;
               end else if (set_dl != cur_ff && set_dl < next_ff) begin
                  next_in = set_dl;
               end
            end
         end
         OP_CHECK: begin
            expired_in = (OUT_TIME_W'(tick_ff) >= in_check_ff);
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff  <= MIN_GAP_RESET;
         safe_gap_ff <= SAFE_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_MIN_GAP:  min_gap_ff  <= csr_wdata;
            CSR_SAFE_GAP: safe_gap_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register: payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= op_type'(req_tuser);
         in_delay_ff <= req_tdata[DELAY_W-1:0];
         in_check_ff <= req_tdata[DELAY_W +: CHECK_W];
      end
   end

   // Timer state and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         cur_ff       <= '0;
         next_ff      <= '0;
         armval_ff    <= '0;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            tick_ff   <= tick_in;
            cur_ff    <= cur_in;
            next_ff   <= next_in;
            armval_ff <= armval_in;
            armed_ff  <= armed_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         wake_ff    <= wake_in;
         dl_ff      <= dl_in;
         expired_ff <= expired_in;
      end
   end

   // The reported count is the state register, which the response beat follows.
   logic [OUT_TIME_W-1:0] ticks_now;
   assign ticks_now  = OUT_TIME_W'(tick_ff);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({ticks_now, expired_ff, dl_ff, wake_ff});

   // An armed compare always belongs to a stored current deadline.
   a_armed_has_current: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (cur_ff != '0))
      else $error("compare armed with an empty current slot");

   // The next slot is never filled while the current slot is empty.
   a_next_implies_current: assert property (@(posedge clock) disable iff (reset)
      (next_ff != '0) |-> (cur_ff != '0))
      else $error("next deadline stored without a current deadline");

   // The request side only stalls when both stages are full and the response is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("request side stalled with room in the pipeline");

   // The state changes only when a request is worked on.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tick_ff) && $stable(cur_ff) && $stable(next_ff))
      else $error("timer state changed without a request");

endmodule

`default_nettype wire
